FILE: sv/ksss_pkg.sv
package ksss_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned WIN_W  = 4;
  localparam logic [WIN_W-1:0] WINDOW_RST = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_INSERT,
    ST_DRAIN
  } ksss_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic pop;
    logic push;
    logic load_out;
    logic out_last;
  } ksss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic one_left;
    logic hold_last;
    logic slot_free;
  } ksss_stat_t;

endpackage

FILE: sv/ksss_ctrl.sv
module ksss_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ksss_pkg::ksss_stat_t stat,
  output ksss_pkg::ksss_cmd_t  cmd
);
  import ksss_pkg::*;

  ksss_state_t state_r;
  ksss_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.full ? ST_EMIT : ST_INSERT;
        end
      end
      ST_EMIT: begin
        if (stat.slot_free) begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        state_nxt = stat.hold_last ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        if (stat.slot_free && stat.one_left) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_EMIT: begin
        cmd.load_out = stat.slot_free;
        cmd.pop      = stat.slot_free;
      end
      ST_INSERT: begin
        cmd.push = 1'b1;
      end
      ST_DRAIN: begin
        cmd.load_out = stat.slot_free;
        cmd.pop      = stat.slot_free;
        cmd.out_last = stat.one_left;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: sv/ksss_dp.sv
module ksss_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ksss_pkg::WIN_W-1:0]          cfg_wdata,
  input  logic signed [ksss_pkg::DATA_W-1:0]  in_value,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ksss_pkg::DATA_W-1:0]  out_value_res,
  output logic                                out_last_res,
  input  ksss_pkg::ksss_cmd_t                 cmd,
  output ksss_pkg::ksss_stat_t                stat
);
  import ksss_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = (CW > WIN_W + 1) ? CW : WIN_W + 1;

  logic [WIN_W-1:0]         window_r;
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic signed [DATA_W-1:0] hold_val_r;
  logic                     hold_last_r;
  logic signed [DATA_W-1:0] store_r   [CAPACITY];
  logic signed [DATA_W-1:0] store_nxt [CAPACITY];
  logic [CAPACITY-1:0]      ge;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r;
  logic [EW-1:0]            count_ext;
  logic [EW-1:0]            lim_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
    end else if (cfg_we) begin
      window_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      hold_val_r  <= in_value;
      hold_last_r <= in_last;
    end
  end

  // The store is kept in ascending order; entry 0 is always the minimum.
  // ge marks entries at or above the insertion point of the held value.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
    logic signed [DATA_W-1:0] below;
    logic signed [DATA_W-1:0] above;
    logic                     ins_here;

    assign ge[g] = (CW'(g) >= count_r) || (hold_val_r < store_r[g]);

    if (g == 0) begin : g_first
      assign below    = hold_val_r;
      assign ins_here = 1'b1;
    end else begin : g_rest
      assign below    = store_r[g-1];
      assign ins_here = !ge[g-1];
    end

    if (g == CAPACITY - 1) begin : g_top
      assign above = store_r[g];
    end else begin : g_mid
      assign above = store_r[g+1];
    end

    always_comb begin
      store_nxt[g] = store_r[g];
      if (cmd.pop) begin
        store_nxt[g] = above;
      end else if (cmd.push && ge[g]) begin
        store_nxt[g] = ins_here ? hold_val_r : below;
      end
    end

    always_ff @(posedge clk) begin
      store_r[g] <= store_nxt[g];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end else if (cmd.push && (count_r < CW'(CAPACITY))) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value_r <= store_r[0];
      out_last_r  <= cmd.out_last;
    end
  end

  // Count at or above min(window + 1, CAPACITY); this also implies nonempty.
  assign count_ext = EW'(count_r);
  assign lim_ext   = EW'(window_r) + EW'(1);

  assign stat.full      = (count_ext >= lim_ext) || (count_r >= CW'(CAPACITY));
  assign stat.one_left  = (count_r == CW'(1));
  assign stat.hold_last = hold_last_r;
  assign stat.slot_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last_res  = out_last_r;

endmodule

FILE: sv/k_sorted_stream_sorter.sv
// Channel   Ports                                                   Direction
// input     in_valid, in_ready, in_value, in_last                   into the block
// result    out_valid, out_ready, out_value_res, out_last_res       out of the block
// config    cfg_we, cfg_wdata (window)                              into the block
//
// An item is accepted and inserted when nothing is emitted for it, and is accepted,
// emits the minimum and is inserted when the store is at its limit.
// At most one store operation per cycle; an item flagged last then drains the store.
// rst_n is synchronous and active low; it empties the store and sets the window to 3.
// A stalled result channel holds the controller in its emit or drain step, while the
// next item is still accepted with a result waiting in the output register.
module k_sorted_stream_sorter #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ksss_pkg::DATA_W-1:0]  in_value,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ksss_pkg::DATA_W-1:0]  out_value_res,
  output logic                                out_last_res,
  input  logic                                cfg_we,
  input  logic [ksss_pkg::WIN_W-1:0]          cfg_wdata
);
  import ksss_pkg::*;

  ksss_cmd_t  cmd;
  ksss_stat_t stat;

  // The controller sequences at most one store operation per cycle: capture the
  // item, pop the minimum into the output register if the store is at its
  // limit, insert the new value in order, and on a last item pop until
  // the store is empty.
  ksss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the sorted store, the fill count, the window
  // register and the output register.
  ksss_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_res (out_value_res),
    .out_last_res  (out_last_res),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

FILE: verif/k_sorted_stream_sorter_tb.sv
// Self-checking testbench for the k-sorted stream sorter.
//
// The bench keeps its own picture of the block: the multiset of values held
// in the priority store and the current window setting. Every time an input
// item is accepted, that picture is updated the same way the block must
// update its store, and the values that must come out are queued in order.
// A checker process compares each accepted result against the oldest queued
// expectation. Ties need no special care because equal values cannot be
// told apart on the result port.
//
// The run goes through directed cases first (the reset window, a window of
// zero, a window lowered and raised while the store holds values), then a
// back-pressure case where the receiver stops for a long stretch, and then
// random arrays that are mostly k-sorted with a share of pure noise.
module k_sorted_stream_sorter_tb;
  import ksss_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam int CYCLE_LIMIT = 200000;
  // Comfortably long enough, after the last result has gone out, for the block
  // to finish an insert, so that it can be called idle.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS = 100;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  is_last;
  } sorted_item_t;

  localparam word_t MAX_VALUE = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t MIN_VALUE = {1'b1, {(DATA_W-1){1'b0}}};

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  word_t            in_value = '0;
  logic             in_last = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  word_t            out_value_res;
  logic             out_last_res;
  logic             cfg_we = 1'b0;
  logic [WIN_W-1:0] cfg_wdata = '0;

  // Predicted state of the block and the results still owed by it.
  word_t            held_values[$];
  logic [WIN_W-1:0] window_setting;
  sorted_item_t     expected_sorted[$];

  // Run bookkeeping.
  int               failures = 0;
  int               items_sent = 0;
  int               results_checked = 0;
  int               random_arrays = 0;
  int               cycle_count = 0;
  logic [15:0]      windows_seen = '0;

  // When set, neither side inserts random idle cycles.
  bit               steady = 1'b0;

  // The test bumps the request count; the receiver notices the change and
  // then counts out the hold-off on its own.
  int               hold_off_requests = 0;
  int               hold_off_served = 0;
  int               hold_off_left = 0;

  k_sorted_stream_sorter #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value_res(out_value_res),
    .out_last_res (out_last_res),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Hard stop in case the block hangs or loses a handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_sorted.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void note_failure(string msg);
    if (failures < MAX_REPORTS) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
    failures++;
  endfunction

  // Removes the smallest held value. Callers make sure the store is not empty.
  function automatic word_t pop_smallest();
    int    best;
    word_t v;
    best = 0;
    for (int i = 1; i < held_values.size(); i++) begin
      if (held_values[i] < held_values[best]) begin
        best = i;
      end
    end
    v = held_values[best];
    held_values.delete(best);
    return v;
  endfunction

  // Applies one accepted item to the predicted store and queues the results
  // it causes. When the store is at or above its limit (which can happen
  // after the window was lowered), exactly one smallest value leaves before
  // the new one goes in. A last item empties the store in ascending order.
  function automatic void predict_sorted_output(word_t value, logic is_last);
    int           limit;
    sorted_item_t r;
    limit = int'(window_setting) + 1;
    if (limit > CAPACITY) begin
      limit = CAPACITY;
    end
    if (held_values.size() >= limit && held_values.size() > 0) begin
      r.value = pop_smallest();
      r.is_last = 1'b0;
      expected_sorted.insert(expected_sorted.size(), r);
    end
    if (held_values.size() < CAPACITY) begin
      held_values.insert(held_values.size(), value);
    end
    if (is_last) begin
      while (held_values.size() > 0) begin
        r.value = pop_smallest();
        r.is_last = (held_values.size() == 0);
        expected_sorted.insert(expected_sorted.size(), r);
      end
    end
  endfunction

  // Result checker. Values are sampled at the clock edge, before any of this
  // edge's updates land, so the handshake seen here is the one the block saw.
  always @(posedge clk) begin : check_results
    sorted_item_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_sorted.size() == 0) begin
        note_failure($sformatf("unexpected result value %0d last %0b",
                               $signed(out_value_res), out_last_res));
      end else begin
        want = expected_sorted[0];
        expected_sorted.delete(0);
        results_checked++;
        if (out_value_res !== want.value || out_last_res !== want.is_last) begin
          note_failure($sformatf("expected value %0d last %0b, got value %0d last %0b",
                                 $signed(want.value), want.is_last,
                                 $signed(out_value_res), out_last_res));
        end
      end
    end
  end

  // Receiver. Normally it drops ready at random about one time in ten; during a
  // requested hold-off it keeps ready low for HOLD_OFF_CYCLES, so the store fills
  // and the block has to stall its input.
  always @(posedge clk) begin
    if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready <= 1'b0;
    end else if (hold_off_served != hold_off_requests) begin
      hold_off_served <= hold_off_requests;
      hold_off_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 10);
    end
  end

  // Offers one item and returns at the edge where it is accepted. Valid is
  // left high so that a following item can be offered without a gap.
  task automatic send_item(input word_t value, input logic is_last);
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_last <= is_last;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_sorted_output(value, is_last);
    items_sent++;
  endtask

  // Stops offering items, waits for every owed result, then lets the block
  // finish any insert that produced no result.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (expected_sorted.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle. The extra edge after the write keeps
  // two writes in a row from landing in the same time step.
  task automatic write_window(input logic [WIN_W-1:0] w);
    cfg_wdata <= w;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_setting = w;
    windows_seen[w] = 1'b1;
    @(posedge clk);
  endtask

  // The window after reset is three, so the store holds four values. The
  // extremes of the signed range and a repeated minimum go through it.
  task automatic test_default_window();
    send_item(MAX_VALUE, 1'b0);
    send_item(MIN_VALUE, 1'b0);
    send_item('0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(MIN_VALUE, 1'b0);
    send_item(MAX_VALUE, 1'b1);
    wait_until_drained();
  endtask

  // With a window of zero the store holds one value, so every item pushes the
  // previous one out. The second array has a single item, which must come out
  // alone and marked last.
  task automatic test_window_zero();
    write_window('0);
    send_item(10, 1'b0);
    send_item(3, 1'b0);
    send_item(-3, 1'b1);
    wait_until_drained();
    send_item(42, 1'b1);
    wait_until_drained();
  endtask

  // The store is filled to seven values under a window of six, then the
  // window drops to one: each item now emits exactly one value and the count
  // stays at seven. Raising the window again lets the store grow before the
  // last item drains it.
  task automatic test_window_lowered();
    write_window(4'd6);
    send_item(50, 1'b0);
    send_item(20, 1'b0);
    send_item(70, 1'b0);
    send_item(20, 1'b0);
    send_item(-5, 1'b0);
    send_item(90, 1'b0);
    send_item(30, 1'b0);
    wait_until_drained();
    write_window(4'd1);
    send_item(60, 1'b0);
    send_item(-100, 1'b0);
    wait_until_drained();
    write_window('1);
    send_item(8, 1'b1);
    wait_until_drained();
  endtask

  // Widest window, so the store holds sixteen values, while the receiver
  // stops for a long stretch. The sender keeps offering items without gaps,
  // so the block fills its output register and must drop in_ready. The last
  // item of the array causes the largest possible burst of results.
  task automatic test_backpressure();
    write_window('1);
    steady = 1'b1;
    hold_off_requests++;
    for (int i = 0; i < 40; i++) begin
      send_item(word_t'($urandom()), i == 39);
    end
    steady = 1'b0;
    wait_until_drained();
  endtask

  // Random arrays. Most are built as a sorted run (with small, medium or
  // huge steps, and saturation at the top giving runs of equal values) that
  // is then shuffled within blocks of window+1, so no element is further
  // than the window from its place. About one array in five is pure noise
  // with the extremes mixed in. Sometimes the window changes in the middle
  // of an array while the store holds values.
  task automatic test_random_arrays();
    word_t            arr[$];
    word_t            t;
    longint           acc;
    int               n;
    int               blk;
    int               scale;
    int               split_at;
    int               j;
    int               start_items;
    bit               noise;
    logic [WIN_W-1:0] w;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: w = '0;
        1: w = '1;
        default: w = WIN_W'($urandom_range(0, 15));
      endcase
      write_window(w);
      // A few arrays in the middle of the run go through with no idling.
      steady = (random_arrays >= 4 && random_arrays < 7);
      n = $urandom_range(1, 24);
      noise = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0: scale = 3;
        1: scale = 5000;
        default: scale = 1 << 26;
      endcase
      acc = longint'($signed($urandom()));
      arr.delete();
      for (int i = 0; i < n; i++) begin
        if (noise) begin
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
              0: t = MAX_VALUE;
              1: t = MIN_VALUE;
              2: t = '0;
              default: t = -1;
            endcase
          end else begin
            t = word_t'($urandom());
          end
        end else begin
          acc += $urandom_range(0, scale);
          if (acc > longint'(MAX_VALUE)) begin
            acc = longint'(MAX_VALUE);
          end
          t = word_t'(acc);
        end
        arr.insert(arr.size(), t);
      end
      if (!noise) begin
        blk = int'(w) + 1;
        for (int b = 0; b < n; b += blk) begin
          for (int i = ((b + blk < n) ? b + blk : n) - 1; i > b; i--) begin
            j = $urandom_range(b, i);
            t = arr[i];
            arr[i] = arr[j];
            arr[j] = t;
          end
        end
      end
      split_at = ($urandom_range(0, 5) == 0 && n > 2) ? $urandom_range(1, n - 2) : n;
      for (int i = 0; i < n; i++) begin
        if (i == split_at) begin
          wait_until_drained();
          write_window(WIN_W'($urandom_range(0, 15)));
        end
        send_item(arr[i], i == n - 1);
      end
      wait_until_drained();
      random_arrays++;
    end
    steady = 1'b0;
  endtask

  initial begin
    // Synchronous reset held at the start of the run; the predicted store starts
    // empty with the reset window.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    held_values.delete();
    window_setting = WINDOW_RST;
    windows_seen[WINDOW_RST] = 1'b1;

    test_default_window();
    test_window_zero();
    test_window_lowered();
    test_backpressure();
    test_random_arrays();

    // Give any stray result a chance to show up before the final verdict.
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (expected_sorted.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived",
                             expected_sorted.size()));
    end

    $display("Sent %0d items, %0d of them in %0d random arrays; %0d results checked.",
             items_sent, items_sent - 21 - 40, random_arrays, results_checked);
    $display("Used %0d of 16 window settings, with one long receiver hold-off; %0d failures.",
             $countones(windows_seen), failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
